### hw/rtl/glbs_pkg.sv
// Shared types and constants for the link bring-up sequencer.
package glbs_pkg;

    typedef enum logic [2:0] {
        PH_PROBE     = 3'd0,
        PH_CONFIGURE = 3'd1,
        PH_SWITCH    = 3'd2,
        PH_ACTIVE    = 3'd3,
        PH_RETRY     = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        CFG_PROBE_TIMEOUT  = 3'd0,
        CFG_SWITCH_SETTLE  = 3'd1,
        CFG_COMMAND_GAP    = 3'd2,
        CFG_ACTIVE_TIMEOUT = 3'd3,
        CFG_EXHAUSTED_WAIT = 3'd4,
        CFG_STALE_LIMIT    = 3'd5,
        CFG_STALE_WAIT     = 3'd6,
        CFG_MAX_ATTEMPTS   = 3'd7
    } t_cfg_idx;

    localparam logic [2:0]  CMD_BAUD_SWITCH = 3'd7;
    localparam logic [1:0]  ATTEMPTS_SAT    = 2'd3;

    localparam logic [15:0] RST_PROBE_TIMEOUT  = 16'd1500;
    localparam logic [15:0] RST_SWITCH_SETTLE  = 16'd300;
    localparam logic [15:0] RST_COMMAND_GAP    = 16'd150;
    localparam logic [15:0] RST_ACTIVE_TIMEOUT = 16'd10000;
    localparam logic [15:0] RST_EXHAUSTED_WAIT = 16'd60000;
    localparam logic [15:0] RST_STALE_LIMIT    = 16'd5000;
    localparam logic [15:0] RST_STALE_WAIT     = 16'd10000;
    localparam logic [1:0]  RST_MAX_ATTEMPTS   = 2'd3;

endpackage

### hw/rtl/gps_link_bringup_sequencer_core.sv
// Link bring-up sequencer: tick input stream, one result item per tick.
// Each tick item carries the millisecond time and status flags and yields exactly one
// result item. The block accepts one item per clock cycle; an item passes an input
// register, a combinational state update and a result register, from which its result is
// offered. Throughput drops only while the result register is stalled
// by the downstream side. Configuration writes are accepted in every cycle.
module gps_link_bringup_sequencer_core
    import glbs_pkg::*;
#(
    parameter int BAUD_SLOTS      = 4,
    parameter int CONFIG_COMMANDS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // now_ms[31:0], sentence_event[32], configured[33], tx_ready[34], zero[39:35]
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // send_command[0], command_id[3:1], restart_uart[4], baud_index[6:5],
    // clear_evidence[7], clear_configured[8], clear_fix[9], link_state[12:10], zero[15:13]
    output logic [15:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SLOT_W = (BAUD_SLOTS > 1) ? $clog2(BAUD_SLOTS) : 1;

    logic [15:0] r_probe_timeout, r_switch_settle, r_command_gap, r_active_timeout;
    logic [15:0] r_exhausted_wait, r_stale_limit, r_stale_wait;
    logic [1:0]  r_max_attempts;

    logic        r_in_valid;
    logic [31:0] r_in_now;
    logic        r_in_event, r_in_configured, r_in_tx_ready;

    t_phase            r_phase, n_phase;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [31:0]       r_deadline, n_deadline;
    logic [2:0]        r_next_cmd, n_next_cmd;
    logic [1:0]        r_attempts, n_attempts;
    logic              r_sentence_seen, n_sentence_seen;
    logic              r_heard_any, n_heard_any;
    logic [31:0]       r_last_time, n_last_time;

    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic        out_free, stage_fire;
    logic        o_send, o_restart, o_clr_ev, o_clr_cfg, o_clr_fix;
    logic [2:0]  o_cmd;
    logic        reached, go_probe;
    logic [31:0] deadline_diff, silence;
    logic [SLOT_W:0]   probe_target;
    logic [SLOT_W+1:0] slot_ext;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign stage_fire      = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_timeout  <= RST_PROBE_TIMEOUT;
            r_switch_settle  <= RST_SWITCH_SETTLE;
            r_command_gap    <= RST_COMMAND_GAP;
            r_active_timeout <= RST_ACTIVE_TIMEOUT;
            r_exhausted_wait <= RST_EXHAUSTED_WAIT;
            r_stale_limit    <= RST_STALE_LIMIT;
            r_stale_wait     <= RST_STALE_WAIT;
            r_max_attempts   <= RST_MAX_ATTEMPTS;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROBE_TIMEOUT:  r_probe_timeout  <= i_cfg_data;
                CFG_SWITCH_SETTLE:  r_switch_settle  <= i_cfg_data;
                CFG_COMMAND_GAP:    r_command_gap    <= i_cfg_data;
                CFG_ACTIVE_TIMEOUT: r_active_timeout <= i_cfg_data;
                CFG_EXHAUSTED_WAIT: r_exhausted_wait <= i_cfg_data;
                CFG_STALE_LIMIT:    r_stale_limit    <= i_cfg_data;
                CFG_STALE_WAIT:     r_stale_wait     <= i_cfg_data;
                CFG_MAX_ATTEMPTS:   r_max_attempts   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_now        <= i_s_axis_tdata[31:0];
            r_in_event      <= i_s_axis_tdata[32];
            r_in_configured <= i_s_axis_tdata[33];
            r_in_tx_ready   <= i_s_axis_tdata[34];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_PROBE;
            r_slot          <= '0;
            r_deadline      <= {16'd0, RST_PROBE_TIMEOUT};
            r_next_cmd      <= '0;
            r_attempts      <= '0;
            r_sentence_seen <= 1'b0;
            r_heard_any     <= 1'b0;
            r_last_time     <= '0;
        end else if (stage_fire) begin
            r_phase         <= n_phase;
            r_slot          <= n_slot;
            r_deadline      <= n_deadline;
            r_next_cmd      <= n_next_cmd;
            r_attempts      <= n_attempts;
            r_sentence_seen <= n_sentence_seen;
            r_heard_any     <= n_heard_any;
            r_last_time     <= n_last_time;
        end
    end

    always_comb begin
        n_sentence_seen = r_sentence_seen | r_in_event;
        n_heard_any     = r_heard_any | r_in_event;
        n_last_time     = r_in_event ? r_in_now : r_last_time;
        n_phase         = r_phase;
        n_slot          = r_slot;
        n_deadline      = r_deadline;
        n_next_cmd      = r_next_cmd;
        n_attempts      = r_attempts;
        o_send          = 1'b0;
        o_cmd           = '0;
        o_restart       = 1'b0;
        o_clr_ev        = 1'b0;
        o_clr_cfg       = 1'b0;
        o_clr_fix       = 1'b0;
        go_probe        = 1'b0;
        probe_target    = '0;
        deadline_diff   = r_in_now - r_deadline;
        reached         = !deadline_diff[31];
        silence         = r_in_now - n_last_time;

        case (r_phase)
            PH_PROBE: begin
                if (n_sentence_seen) begin
                    if (r_slot != '0) begin
                        if (r_in_tx_ready) begin
                            o_send     = 1'b1;
                            o_cmd      = CMD_BAUD_SWITCH;
                            n_phase    = PH_SWITCH;
                            n_deadline = r_in_now + {16'd0, r_switch_settle};
                        end
                    end else begin
                        n_phase    = PH_CONFIGURE;
                        n_next_cmd = '0;
                        n_deadline = r_in_now;
                        o_clr_ev   = 1'b1;
                    end
                end else if (reached) begin
                    if (({1'b0, r_slot} + (SLOT_W+1)'(1)) < (SLOT_W+1)'(BAUD_SLOTS)) begin
                        go_probe     = 1'b1;
                        probe_target = {1'b0, r_slot} + (SLOT_W+1)'(1);
                    end else begin
                        o_clr_fix  = 1'b1;
                        o_clr_cfg  = 1'b1;
                        n_phase    = PH_RETRY;
                        n_deadline = r_in_now + {16'd0, r_exhausted_wait};
                    end
                end
            end
            PH_CONFIGURE: begin
                if (reached) begin
                    if (r_next_cmd < 3'(CONFIG_COMMANDS)) begin
                        if (r_in_tx_ready) begin
                            o_send     = 1'b1;
                            o_cmd      = r_next_cmd;
                            n_next_cmd = r_next_cmd + 3'd1;
                            n_deadline = r_in_now + {16'd0, r_command_gap};
                        end
                    end else begin
                        n_phase    = PH_ACTIVE;
                        n_deadline = r_in_now + {16'd0, r_active_timeout};
                        if (r_attempts < ATTEMPTS_SAT) begin
                            n_attempts = r_attempts + 2'd1;
                        end
                    end
                end
            end
            PH_SWITCH: begin
                go_probe = reached;
            end
            PH_ACTIVE: begin
                if (!r_in_configured && reached && (r_attempts < r_max_attempts)) begin
                    n_phase    = PH_CONFIGURE;
                    n_next_cmd = '0;
                    n_deadline = r_in_now;
                    o_clr_ev   = 1'b1;
                end
                if (n_heard_any && (silence > {16'd0, r_stale_limit})) begin
                    o_clr_cfg  = 1'b1;
                    o_clr_fix  = 1'b1;
                    n_phase    = PH_RETRY;
                    n_deadline = r_in_now + {16'd0, r_stale_wait};
                end
            end
            PH_RETRY: begin
                go_probe = reached;
            end
            default: begin
                go_probe = 1'b1;
            end
        endcase

        if (go_probe) begin
            if (probe_target >= (SLOT_W+1)'(BAUD_SLOTS)) begin
                probe_target = '0;
            end
            o_clr_cfg       = 1'b1;
            o_clr_ev        = 1'b1;
            o_restart       = 1'b1;
            n_attempts      = '0;
            n_slot          = probe_target[SLOT_W-1:0];
            n_sentence_seen = 1'b0;
            n_phase         = PH_PROBE;
            n_deadline      = r_in_now + {16'd0, r_probe_timeout};
        end

        slot_ext = {2'b00, n_slot};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_fire) begin
            r_out_data <= {3'b000, n_phase, o_clr_fix, o_clr_cfg, o_clr_ev,
                           slot_ext[1:0], o_restart, o_cmd, o_send};
        end
    end

    a_idle_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (r_out_data[3:1] == 3'd0))
        else $error("command id set without a command");

    a_restart_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[4]) |-> (r_out_data[12:10] == PH_PROBE))
        else $error("uart restart outside probing");

    a_fix_clear_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[9]) |-> (r_out_data[12:10] == PH_RETRY))
        else $error("fix cleared outside retry wait");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_fire |=> r_out_valid)
        else $error("tick lost between stages");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

endmodule
